[sv/tcl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types, character codes and a width helper for the command line tokenizer.
// ----------------------------------------------------------------------------
package tcl_pkg;

   localparam int LINE_LIMIT_W   = 11;
   localparam int TOKEN_LENGTH_W = 9;
   localparam int TOKEN_COUNT_W  = 7;
   localparam int CSR_DATA_W     = 11;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_LINE_LIMIT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TOKEN_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TOKEN_COUNT  = 2'd2;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_VT      = 8'h0B;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG = 2'd1;
   localparam logic [1:0] ERR_TOO_MANY = 2'd2;

   localparam logic [1:0] ID_NONE     = 2'd0;
   localparam logic [1:0] ID_POSITIVE = 2'd1;
   localparam logic [1:0] ID_ZERO     = 2'd2;
   localparam logic [1:0] ID_NEGATIVE = 2'd3;

   localparam logic [30:0] ID_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic        token_char_valid;
      logic [7:0]  token_char;
      logic [5:0]  token_number;
      logic        line_end;
      logic        line_empty;
      logic [1:0]  error_code;
      logic [1:0]  id_kind;
      logic [30:0] id_value;
      logic [5:0]  arg_count;
   } result_type;

   // width of a limit register that must hold both its field and its default
   function automatic int limit_width(input int max_val, input int min_width);
      int w;
      w = $clog2(max_val + 1);
      return (w > min_width) ? w : min_width;
   endfunction

endpackage
`default_nettype wire

[sv/tcl_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcl_cfg
// Limit registers, loaded with their defaults at reset and written over csr.
// ----------------------------------------------------------------------------
module tcl_cfg #(
   parameter int MAX_LINE        = 1024,
   parameter int MAX_TOKENS      = 64,
   parameter int MAX_TOKEN_CHARS = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [tcl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [tcl_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [tcl_pkg::limit_width(MAX_LINE, tcl_pkg::LINE_LIMIT_W)-1:0]
                                                    line_limit,
   output logic [tcl_pkg::limit_width(MAX_TOKEN_CHARS, tcl_pkg::TOKEN_LENGTH_W)-1:0]
                                                    token_length_limit,
   output logic [tcl_pkg::limit_width(MAX_TOKENS, tcl_pkg::TOKEN_COUNT_W)-1:0]
                                                    token_count_limit
);
   import tcl_pkg::*;

   localparam int LLW = limit_width(MAX_LINE, LINE_LIMIT_W);
   localparam int TLW = limit_width(MAX_TOKEN_CHARS, TOKEN_LENGTH_W);
   localparam int TCW = limit_width(MAX_TOKENS, TOKEN_COUNT_W);

   logic [LLW-1:0] line_limit_ff;
   logic [TLW-1:0] token_length_limit_ff;
   logic [TCW-1:0] token_count_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff         <= LLW'(MAX_LINE);
         token_length_limit_ff <= TLW'(MAX_TOKEN_CHARS);
         token_count_limit_ff  <= TCW'(MAX_TOKENS);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LINE_LIMIT: begin
               line_limit_ff <= LLW'(csr_data[LINE_LIMIT_W-1:0]);
            end
            REG_TOKEN_LENGTH: begin
               token_length_limit_ff <= TLW'(csr_data[TOKEN_LENGTH_W-1:0]);
            end
            REG_TOKEN_COUNT: begin
               token_count_limit_ff <= TCW'(csr_data[TOKEN_COUNT_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   assign line_limit         = line_limit_ff;
   assign token_length_limit = token_length_limit_ff;
   assign token_count_limit  = token_count_limit_ff;

endmodule
`default_nettype wire

[sv/tcl_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcl_scan
// Per-line scanner state and the per-byte update that forms one result.
// ----------------------------------------------------------------------------
module tcl_scan #(
   parameter int MAX_LINE        = 1024,
   parameter int MAX_TOKENS      = 64,
   parameter int MAX_TOKEN_CHARS = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          ch,
   input  wire logic [tcl_pkg::limit_width(MAX_LINE, tcl_pkg::LINE_LIMIT_W)-1:0]
                                    line_limit,
   input  wire logic [tcl_pkg::limit_width(MAX_TOKEN_CHARS, tcl_pkg::TOKEN_LENGTH_W)-1:0]
                                    token_length_limit,
   input  wire logic [tcl_pkg::limit_width(MAX_TOKENS, tcl_pkg::TOKEN_COUNT_W)-1:0]
                                    token_count_limit,
   output tcl_pkg::result_type      result
);
   import tcl_pkg::*;

   localparam int LLW = limit_width(MAX_LINE, LINE_LIMIT_W);
   localparam int TLW = limit_width(MAX_TOKEN_CHARS, TOKEN_LENGTH_W);
   localparam int TCW = limit_width(MAX_TOKENS, TOKEN_COUNT_W);

   typedef enum logic [1:0] {
      PH_START,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   logic [LLW-1:0] byte_count_ff,   byte_count_in;
   logic           in_comment_ff,   in_comment_in;
   logic           in_token_ff,     in_token_in;
   logic [TCW-1:0] token_count_ff,  token_count_in;
   logic [TLW-1:0] token_length_ff, token_length_in;
   logic [1:0]     error_seen_ff,   error_seen_in;
   logic           first_neg_ff,    first_neg_in;
   phase_type      first_phase_ff,  first_phase_in;
   logic [30:0]    id_acc_ff,       id_acc_in;
   logic           lone_zero_ff,    lone_zero_in;

   logic [LLW-1:0] bc_inc;
   logic [TCW-1:0] tc_plus;
   logic [TCW-1:0] tc_closed;
   logic [TLW-1:0] tl_plus;
   logic [1:0]     err_closed;
   logic           token_counted;
   logic           line_close;
   logic           is_digit;
   logic           is_sep;
   logic [34:0]    acc_sum;
   logic [30:0]    acc_sat;
   logic [1:0]     start;

   always_comb begin
      bc_inc        = byte_count_ff + 1'b1;
      tc_plus       = token_count_ff + 1'b1;
      tl_plus       = token_length_ff + 1'b1;
      token_counted = in_token_ff && (error_seen_ff == ERR_NONE);
      tc_closed     = token_counted ? tc_plus : token_count_ff;
      err_closed    = (token_counted && (tc_plus >= token_count_limit)) ?
                      ERR_TOO_MANY : error_seen_ff;
      line_close    = (ch == CH_NL) || (bc_inc >= line_limit);
      is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
      is_sep        = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL) ||
                      (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
      acc_sum       = {1'b0, id_acc_ff, 3'b000} + {3'b000, id_acc_ff, 1'b0} +
                      {31'd0, ch[3:0]};
      acc_sat       = (acc_sum > {4'd0, ID_MAX}) ? ID_MAX : acc_sum[30:0];
      start         = 2'd1;

      result          = '0;
      byte_count_in   = bc_inc;
      in_comment_in   = in_comment_ff;
      in_token_in     = in_token_ff;
      token_count_in  = token_count_ff;
      token_length_in = token_length_ff;
      error_seen_in   = error_seen_ff;
      first_neg_in    = first_neg_ff;
      first_phase_in  = first_phase_ff;
      id_acc_in       = id_acc_ff;
      lone_zero_in    = lone_zero_ff;

      priority if (line_close) begin
         result.line_end = 1'b1;
         priority if (err_closed != ERR_NONE) begin
            result.error_code = err_closed;
         end else if (tc_closed == '0) begin
            result.line_empty = 1'b1;
         end else begin
            priority if (lone_zero_ff) begin
               result.id_kind = ID_ZERO;
               start          = 2'd2;
            end else if (id_acc_ff != '0) begin
               if (first_neg_ff) begin
                  result.id_kind = ID_NEGATIVE;
               end else begin
                  result.id_kind  = ID_POSITIVE;
                  result.id_value = id_acc_ff;
               end
               start = 2'd2;
            end else begin
            end
            result.arg_count = (tc_closed > TCW'(start)) ?
                               6'((tc_closed - TCW'(start)) & TCW'(63)) : 6'd0;
         end
         byte_count_in   = '0;
         in_comment_in   = 1'b0;
         in_token_in     = 1'b0;
         token_count_in  = '0;
         token_length_in = '0;
         error_seen_in   = ERR_NONE;
         first_neg_in    = 1'b0;
         first_phase_in  = PH_START;
         id_acc_in       = '0;
         lone_zero_in    = 1'b0;
      end else if (in_comment_ff || (error_seen_ff != ERR_NONE)) begin
      end else if ((ch == CH_HASH) || (ch == CH_NUL) || is_sep) begin
         in_token_in     = 1'b0;
         token_length_in = '0;
         token_count_in  = tc_closed;
         error_seen_in   = err_closed;
         in_comment_in   = !is_sep;
      end else if (tl_plus >= token_length_limit) begin
         error_seen_in = ERR_TOO_LONG;
      end else begin
         result.token_char_valid = 1'b1;
         result.token_char       = ch;
         result.token_number     = token_count_ff[5:0];
         token_length_in         = tl_plus;
         in_token_in             = 1'b1;
         if (token_count_ff == '0) begin
            lone_zero_in = (token_length_ff == '0) && (ch == CH_ZERO);
            unique case (first_phase_ff)
               PH_START: begin
                  priority if (ch == CH_MINUS) begin
                     first_neg_in   = 1'b1;
                     first_phase_in = PH_DIGITS;
                  end else if (ch == CH_PLUS) begin
                     first_phase_in = PH_DIGITS;
                  end else if (is_digit) begin
                     id_acc_in      = acc_sat;
                     first_phase_in = PH_DIGITS;
                  end else begin
                     first_phase_in = PH_DONE;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) begin
                     id_acc_in = acc_sat;
                  end else begin
                     first_phase_in = PH_DONE;
                  end
               end
               PH_DONE: begin
               end
               default: begin
                  first_phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         in_comment_ff   <= 1'b0;
         in_token_ff     <= 1'b0;
         token_count_ff  <= '0;
         token_length_ff <= '0;
         error_seen_ff   <= ERR_NONE;
         first_neg_ff    <= 1'b0;
         first_phase_ff  <= PH_START;
         id_acc_ff       <= '0;
         lone_zero_ff    <= 1'b0;
      end else if (step) begin
         byte_count_ff   <= byte_count_in;
         in_comment_ff   <= in_comment_in;
         in_token_ff     <= in_token_in;
         token_count_ff  <= token_count_in;
         token_length_ff <= token_length_in;
         error_seen_ff   <= error_seen_in;
         first_neg_ff    <= first_neg_in;
         first_phase_ff  <= first_phase_in;
         id_acc_ff       <= id_acc_in;
         lone_zero_ff    <= lone_zero_in;
      end
   end

endmodule
`default_nettype wire

[sv/text_command_line_tokenizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_command_line_tokenizer
// Splits a byte stream of command lines into tokens and line summaries.
// Each byte passes an input register and then a result register before its
// result is valid. Throughput: one byte per cycle while rsp_ready keeps the
// result register from stalling.
// Synchronous reset clears the line state and loads the default limits;
// no clearing pass.
// ----------------------------------------------------------------------------
module text_command_line_tokenizer #(
   parameter int MAX_LINE        = 1024,
   parameter int MAX_TOKENS      = 64,
   parameter int MAX_TOKEN_CHARS = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_ch,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_token_char_valid,
   output logic [7:0]                           rsp_token_char,
   output logic [5:0]                           rsp_token_number,
   output logic                                 rsp_line_end,
   output logic                                 rsp_line_empty,
   output logic [1:0]                           rsp_error_code,
   output logic [1:0]                           rsp_id_kind,
   output logic [30:0]                          rsp_id_value,
   output logic [5:0]                           rsp_arg_count,
   input  wire logic                            csr_we,
   input  wire logic [tcl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tcl_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tcl_pkg::*;

   localparam int LLW = limit_width(MAX_LINE, LINE_LIMIT_W);
   localparam int TLW = limit_width(MAX_TOKEN_CHARS, TOKEN_LENGTH_W);
   localparam int TCW = limit_width(MAX_TOKENS, TOKEN_COUNT_W);

   logic [LLW-1:0] line_limit;
   logic [TLW-1:0] token_length_limit;
   logic [TCW-1:0] token_count_limit;

   logic       in_valid_ff,  in_valid_in;
   logic [7:0] in_ch_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type scan_result;
   logic       advance;
   logic       req_transfer;

   tcl_cfg #(
      .MAX_LINE        (MAX_LINE),
      .MAX_TOKENS      (MAX_TOKENS),
      .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
   ) u_cfg (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .line_limit         (line_limit),
      .token_length_limit (token_length_limit),
      .token_count_limit  (token_count_limit)
   );

   tcl_scan #(
      .MAX_LINE        (MAX_LINE),
      .MAX_TOKENS      (MAX_TOKENS),
      .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
   ) u_scan (
      .clock              (clock),
      .reset              (reset),
      .step               (advance),
      .ch                 (in_ch_ff),
      .line_limit         (line_limit),
      .token_length_limit (token_length_limit),
      .token_count_limit  (token_count_limit),
      .result             (scan_result)
   );

   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || advance;
      req_transfer = req_valid && req_ready;
      in_valid_in  = req_transfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_ch_ff <= req_ch;
      end
      if (advance) begin
         out_ff <= scan_result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_token_char_valid = out_ff.token_char_valid;
   assign rsp_token_char       = out_ff.token_char;
   assign rsp_token_number     = out_ff.token_number;
   assign rsp_line_end         = out_ff.line_end;
   assign rsp_line_empty       = out_ff.line_empty;
   assign rsp_error_code       = out_ff.error_code;
   assign rsp_id_kind          = out_ff.id_kind;
   assign rsp_id_value         = out_ff.id_value;
   assign rsp_arg_count        = out_ff.arg_count;

endmodule
`default_nettype wire

[tb/text_command_line_tokenizer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_line_tokenizer_checker
// Watches the byte, result and register ports of the tokenizer. Every accepted
// byte runs through a tokenizer model with its own limits and line state. The
// results it gives are queued and compared field by field with the results
// the block delivers. Reports mismatches and the number of results in flight.
// ----------------------------------------------------------------------------
module text_command_line_tokenizer_checker #(
   parameter int MAX_LINE        = 1024,
   parameter int MAX_TOKENS      = 64,
   parameter int MAX_TOKEN_CHARS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_ch,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_token_char_valid,
   input  logic [7:0]                      rsp_token_char,
   input  logic [5:0]                      rsp_token_number,
   input  logic                            rsp_line_end,
   input  logic                            rsp_line_empty,
   input  logic [1:0]                      rsp_error_code,
   input  logic [1:0]                      rsp_id_kind,
   input  logic [30:0]                     rsp_id_value,
   input  logic [5:0]                      rsp_arg_count,
   input  logic                            csr_we,
   input  logic [tcl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcl_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              failures,
   output int                              pending
);

   import tcl_pkg::*;

   // progress through a possible numeric id in the first token
   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   logic [10:0] line_limit;
   logic [8:0]  token_length_limit;
   logic [6:0]  token_count_limit;

   logic [10:0] byte_count;
   logic        in_comment;
   logic        in_token;
   logic [6:0]  token_count;
   logic [8:0]  token_length;
   logic [1:0]  error_seen;
   logic        first_negative;
   logic [1:0]  first_phase;
   logic [30:0] id_accumulator;
   logic        first_is_lone_zero;

   result_type  expected_results [$];
   result_type  predicted;
   result_type  wanted;
   result_type  delivered;

   initial begin
      failures = 0;
      pending  = 0;
   end

   task automatic clear_line_state();
      byte_count         = '0;
      in_comment         = 1'b0;
      in_token           = 1'b0;
      token_count        = '0;
      token_length       = '0;
      error_seen         = ERR_NONE;
      first_negative     = 1'b0;
      first_phase        = PH_START;
      id_accumulator     = '0;
      first_is_lone_zero = 1'b0;
   endtask

   function automatic logic is_blank(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
   endfunction

   task automatic close_open_token();
      if (in_token && error_seen == ERR_NONE) begin
         token_count = token_count + 7'd1;
         if (token_count >= token_count_limit)
            error_seen = ERR_TOO_MANY;
      end
      in_token     = 1'b0;
      token_length = '0;
   endtask

   task automatic accumulate_digit(input logic [7:0] c);
      longint unsigned v;
      v = longint'(id_accumulator) * 10 + longint'(c - CH_ZERO);
      id_accumulator = (v > longint'(ID_MAX)) ? ID_MAX : v[30:0];
   endtask

   task automatic track_id(input logic [7:0] c, input logic [8:0] pos);
      logic digit;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      first_is_lone_zero = (pos == 9'd0) && (c == CH_ZERO);
      case (first_phase)
         PH_START: begin
            if (c == CH_MINUS) begin
               first_negative = 1'b1;
               first_phase    = PH_DIGITS;
            end else if (c == CH_PLUS) begin
               first_phase = PH_DIGITS;
            end else if (digit) begin
               accumulate_digit(c);
               first_phase = PH_DIGITS;
            end else begin
               first_phase = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (digit)
               accumulate_digit(c);
            else
               first_phase = PH_DONE;
         end
         default: ;
      endcase
   endtask

   task automatic tokenize_byte(input logic [7:0] c, output result_type res);
      int start;
      res        = '0;
      start      = 1;
      byte_count = byte_count + 11'd1;
      if (c == CH_NL || byte_count >= line_limit) begin
         close_open_token();
         res.line_end = 1'b1;
         if (error_seen != ERR_NONE) begin
            res.error_code = error_seen;
         end else if (token_count == 7'd0) begin
            res.line_empty = 1'b1;
         end else begin
            if (first_is_lone_zero) begin
               res.id_kind = ID_ZERO;
               start       = 2;
            end else if (id_accumulator != '0) begin
               if (first_negative) begin
                  res.id_kind = ID_NEGATIVE;
               end else begin
                  res.id_kind  = ID_POSITIVE;
                  res.id_value = id_accumulator;
               end
               start = 2;
            end
            if (int'(token_count) > start)
               res.arg_count = 6'(int'(token_count) - start);
         end
         clear_line_state();
      end else if (!in_comment && error_seen == ERR_NONE) begin
         if (c == CH_HASH || c == CH_NUL) begin
            close_open_token();
            in_comment = 1'b1;
         end else if (is_blank(c)) begin
            close_open_token();
         end else if (int'(token_length) + 1 >= int'(token_length_limit)) begin
            error_seen = ERR_TOO_LONG;
         end else begin
            res.token_char_valid = 1'b1;
            res.token_char       = c;
            res.token_number     = token_count[5:0];
            if (token_count == 7'd0)
               track_id(c, token_length);
            token_length = token_length + 9'd1;
            in_token     = 1'b1;
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [30:0] want,
                                input logic [30:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         line_limit         = 11'(MAX_LINE);
         token_length_limit = 9'(MAX_TOKEN_CHARS);
         token_count_limit  = 7'(MAX_TOKENS);
         clear_line_state();
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_LINE_LIMIT:   line_limit         = csr_data[10:0];
               REG_TOKEN_LENGTH: token_length_limit = csr_data[8:0];
               REG_TOKEN_COUNT:  token_count_limit  = csr_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            tokenize_byte(req_ch, predicted);
            expected_results.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no expectation waiting");
               failures++;
            end else begin
               wanted    = expected_results.pop_front();
               delivered = '{rsp_token_char_valid, rsp_token_char, rsp_token_number,
                             rsp_line_end, rsp_line_empty, rsp_error_code,
                             rsp_id_kind, rsp_id_value, rsp_arg_count};
               compare_field("token_char_valid", wanted.token_char_valid,
                             delivered.token_char_valid);
               compare_field("token_char", wanted.token_char, delivered.token_char);
               compare_field("token_number", wanted.token_number,
                             delivered.token_number);
               compare_field("line_end", wanted.line_end, delivered.line_end);
               compare_field("line_empty", wanted.line_empty, delivered.line_empty);
               compare_field("error_code", wanted.error_code, delivered.error_code);
               compare_field("id_kind", wanted.id_kind, delivered.id_kind);
               compare_field("id_value", wanted.id_value, delivered.id_value);
               compare_field("arg_count", wanted.arg_count, delivered.arg_count);
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

[tb/text_command_line_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_line_tokenizer_tb
// Byte stream stimulus for the command line tokenizer. A short directed run
// covers ids, comments, separators and byte extremes; then random command
// lines, well formed with random content plus some noise, run under a series
// of limit settings including the extremes, with random idling on both sides in all but one phase.
// ----------------------------------------------------------------------------
module text_command_line_tokenizer_tb;

   import tcl_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASE_BYTES  = 180;
   localparam int PHASES       = 11;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_ch    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_token_char_valid;
   logic [7:0]             rsp_token_char;
   logic [5:0]             rsp_token_number;
   logic                   rsp_line_end;
   logic                   rsp_line_empty;
   logic [1:0]             rsp_error_code;
   logic [1:0]             rsp_id_kind;
   logic [30:0]            rsp_id_value;
   logic [5:0]             rsp_arg_count;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   int                     failures;
   int                     pending;
   int                     cycle_count = 0;
   logic                   throttle    = 1'b1;
   logic [7:0]             line_buf [$];

   logic [7:0] directed_bytes [$] = '{
      CH_ZERO, CH_SPACE, 8'h61, CH_NL,
      CH_MINUS, 8'h37, CH_SPACE, 8'h62, 8'hFF, CH_NL,
      CH_PLUS, CH_TAB, CH_HASH, 8'h7A, CH_NL,
      8'h80, CH_NUL, 8'h71, CH_NL,
      CH_SPACE, CH_VT, CH_FF, CH_CR, CH_NL
   };

   int phase_line  [9] = '{1024, 2047, 2, 0, 1, 40, 100, 16, 300};
   int phase_chars [9] = '{256, 2047, 2, 1, 0, 8, 20, 4, 48};
   int phase_count [9] = '{64, 2047, 2, 0, 1, 5, 10, 3, 20};

   text_command_line_tokenizer dut (.*);

   text_command_line_tokenizer_checker u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= !(throttle && $urandom_range(0, 99) < 18);

   task automatic send_byte(input logic [7:0] b);
      while (throttle && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic program_limits(input logic [CSR_DATA_W-1:0] line_max,
                                 input logic [CSR_DATA_W-1:0] chars_max,
                                 input logic [CSR_DATA_W-1:0] count_max);
      csr_we    <= 1'b1;
      csr_index <= REG_LINE_LIMIT;
      csr_data  <= line_max;
      @(posedge clock);
      csr_index <= REG_TOKEN_LENGTH;
      csr_data  <= chars_max;
      @(posedge clock);
      csr_index <= REG_TOKEN_COUNT;
      csr_data  <= count_max;
      @(posedge clock);
      // writes to the spare index must have no effect
      csr_index <= REG_UNUSED;
      csr_data  <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 4))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         3:       return CH_VT;
         default: return CH_FF;
      endcase
   endfunction

   function automatic logic [7:0] pick_word_char();
      logic [7:0] c;
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom_range(8'h80, 8'hFF));
      do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CH_HASH);
      return c;
   endfunction

   task automatic append_digits(input int n);
      repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   task automatic append_gap();
      repeat ($urandom_range(1, 3)) line_buf.push_back(pick_separator());
   endtask

   task automatic build_line();
      int roll;
      int args;
      line_buf.delete();
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (roll < 17) begin
         if ($urandom_range(0, 1)) append_gap();
      end else begin
         if ($urandom_range(0, 4) == 0) append_gap();
         case ($urandom_range(0, 8))
            0: ;
            1: append_digits($urandom_range(1, 4));
            2: append_digits($urandom_range(10, 14));
            3: line_buf.push_back(CH_ZERO);
            4: begin
               line_buf.push_back(CH_MINUS);
               append_digits($urandom_range(1, 11));
            end
            5: begin
               line_buf.push_back(CH_PLUS);
               append_digits($urandom_range(0, 3));
            end
            6: begin
               line_buf.push_back($urandom_range(0, 1) ? CH_ZERO : CH_MINUS);
               line_buf.push_back(CH_ZERO);
            end
            default: begin
               append_digits($urandom_range(1, 3));
               repeat ($urandom_range(1, 3)) line_buf.push_back(pick_word_char());
            end
         endcase
         if (line_buf.size() != 0) append_gap();
         repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
         args = ($urandom_range(0, 49) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 5);
         repeat (args) begin
            append_gap();
            repeat (($urandom_range(0, 49) == 0) ? $urandom_range(200, 300)
                                                : $urandom_range(1, 6))
               line_buf.push_back(pick_word_char());
         end
         if ($urandom_range(0, 3) == 0) append_gap();
         if ($urandom_range(0, 6) == 0) begin
            line_buf.push_back($urandom_range(0, 1) ? CH_HASH : CH_NUL);
            repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
      if (roll >= 12 || $urandom_range(0, 1)) line_buf.push_back(CH_NL);
   endtask

   task automatic run_traffic(input int quota);
      int sent;
      logic paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < quota) begin
         build_line();
         foreach (line_buf[i]) send_byte(line_buf[i]);
         sent += line_buf.size();
         // hold the sender once until the block has drained
         if (!paused && sent >= quota / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      for (int p = 0; p < PHASES; p++) begin
         wait_for_results();
         // phase 1 runs with no idling on either side
         throttle <= (p != 1);
         if (p < 9)
            program_limits(CSR_DATA_W'(phase_line[p]), CSR_DATA_W'(phase_chars[p]),
                           CSR_DATA_W'(phase_count[p]));
         else
            program_limits(CSR_DATA_W'($urandom_range(2, 200)),
                           CSR_DATA_W'($urandom_range(2, 40)),
                           CSR_DATA_W'($urandom_range(2, 16)));
         run_traffic(PHASE_BYTES);
      end
      wait_for_results();
      repeat (4) @(posedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
sv/tcl_pkg.sv
sv/tcl_cfg.sv
sv/tcl_scan.sv
sv/text_command_line_tokenizer.sv
tb/text_command_line_tokenizer_checker.sv
tb/text_command_line_tokenizer_tb.sv
